/* design/tet_element_stiffness_macros.svh */
// assertion macros for the element stiffness block
`ifndef TET_ELEMENT_STIFFNESS_MACROS_SVH
`define TET_ELEMENT_STIFFNESS_MACROS_SVH
// assert that a implies b in the same cycle
`define TES_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define TES_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* design/tes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_pkg
// types shared by the element stiffness block
// ----------------------------------------------------------------------------
package tes_pkg;
  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } tes_state_t;
  // operand phase within one entry
  typedef enum logic [1:0] {
    PH_T,
    PH_D,
    PH_E
  } tes_phase_t;
  localparam logic KIND_HEADER = 1'b0;
endpackage

/* design/tet_element_stiffness.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_element_stiffness
// Local 4x4 stiffness matrix of a linear tetrahedron, vol * gi' S gj, Q16.16.
// A header or an early-slot gradient item is stored on acceptance. The item of the last
// slot starts the sixteen entries; each entry runs 13 products through one
// shared multiplier, each multiplied in ST_MUL and then shifted, rounded,
// saturated and accumulated in ST_ACC, and the entry then goes out in ST_OUT.
// in_tready stays low until the last entry is taken. Entries come out in
// row-major order with tlast on the sixteenth.
// ----------------------------------------------------------------------------
module tet_element_stiffness
  import tes_pkg::*;
#(
  parameter int NODES_PER_ELEMENT = 4,
  parameter int DATA_WIDTH        = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tdata: sxx, sxy, sxz, syy, syz, szz, volume, grad_x, grad_y, grad_z, node_slot
  input  logic [10*DATA_WIDTH+7:0] in_tdata,
  // tuser: kind
  input  logic                    in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // tdata: row, col, entry_value, saturated
  output logic [DATA_WIDTH+7:0]   out_tdata,
  output logic                    out_tlast
);
  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  // accumulator holds three saturated values
  localparam int AW = DW + 2;
  localparam logic signed [AW-1:0] MAXV = AW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);
  // index of the last node slot
  localparam logic [1:0] LAST_NODE = 2'(NODES_PER_ELEMENT - 1);

  `include "tet_element_stiffness_macros.svh"

  // tensor, volume and gradient storage
  logic signed [DW-1:0] tens_r [6];
  logic signed [DW-1:0] vol_r;
  logic signed [DW-1:0] grad_r [NODES_PER_ELEMENT*3];

  tes_state_t state_r, state_nxt;
  tes_phase_t phase_r;
  logic [1:0] i_r, j_r, k_r, l_r;
  logic signed [AW-1:0] acc_r, dacc_r;
  logic signed [DW-1:0] t_r;
  logic signed [PW-1:0] prod_r;
  logic clip_r;
  logic [DW+7:0] odata_r;
  logic olast_r;

  logic in_acc;
  logic [1:0] slot;
  assign in_acc = in_tvalid && in_tready;
  assign slot   = in_tdata[10*DW+1:10*DW];

  // tensor lookup, symmetric
  function automatic logic [2:0] tidx(input logic [1:0] a, input logic [1:0] b);
    logic [3:0] s;
    s = {a, b};
    case (s)
      4'h0: tidx = 3'd0;
      4'h1, 4'h4: tidx = 3'd1;
      4'h2, 4'h8: tidx = 3'd2;
      4'h5: tidx = 3'd3;
      4'h6, 4'h9: tidx = 3'd4;
      default: tidx = 3'd5;
    endcase
  endfunction

  // operand selection for the shared multiplier
  logic signed [DW-1:0] opa, opb;
  always_comb begin
    case (phase_r)
      PH_T: begin
        opa = tens_r[tidx(k_r, l_r)];
        opb = grad_r[{j_r, 2'b00} - {2'b00, j_r} + {2'b00, l_r}];
      end
      PH_D: begin
        opa = grad_r[{i_r, 2'b00} - {2'b00, i_r} + {2'b00, k_r}];
        opb = t_r;
      end
      default: begin
        opa = vol_r;
        opb = dacc_r[DW-1:0];
      end
    endcase
  end

  // floor shift by 16 and saturation of the registered product
  logic signed [PW-1:0] shq;
  logic signed [AW-1:0] prs;
  logic pclip;
  always_comb begin
    shq = prod_r >>> 16;
    pclip = 1'b0;
    if (shq > PW'(MAXV)) begin
      prs = MAXV; pclip = 1'b1;
    end else if (shq < PW'(MINV)) begin
      prs = MINV; pclip = 1'b1;
    end else begin
      prs = AW'(shq);
    end
  end

  // saturation of an accumulated sum
  function automatic logic signed [AW:0] satf(input logic signed [AW-1:0] v);
    if (v > MAXV) satf = {1'b1, MAXV};
    else if (v < MINV) satf = {1'b1, MINV};
    else satf = {1'b0, v};
  endfunction

  logic signed [AW-1:0] sum;
  logic signed [AW:0] ssat;
  assign sum  = acc_r + prs;
  assign ssat = satf(sum);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && in_tuser != KIND_HEADER && slot == LAST_NODE) state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (phase_r == PH_E) state_nxt = ST_OUT;
        else state_nxt = ST_MUL;
      end
      ST_OUT: begin
        if (out_tready) begin
          if (i_r == LAST_NODE && j_r == LAST_NODE) state_nxt = ST_IDLE;
          else state_nxt = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    out_tdata  = odata_r;
    out_tlast  = olast_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_T;
      i_r <= '0; j_r <= '0; k_r <= '0; l_r <= '0;
      vol_r <= '0;
      for (int n = 0; n < 6; n++) tens_r[n] <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser == KIND_HEADER) begin
        for (int n = 0; n < 6; n++) tens_r[n] <= in_tdata[n*DW +: DW];
        vol_r <= in_tdata[6*DW +: DW];
      end
      if (state_r == ST_IDLE) begin
        phase_r <= PH_T;
        i_r <= '0; j_r <= '0; k_r <= '0; l_r <= '0;
      end
      if (state_r == ST_ACC) begin
        case (phase_r)
          PH_T: begin
            if (l_r == 2'd2) begin
              l_r <= '0; phase_r <= PH_D;
            end else l_r <= l_r + 2'd1;
          end
          PH_D: begin
            if (k_r == 2'd2) begin
              k_r <= '0; phase_r <= PH_E;
            end else begin
              k_r <= k_r + 2'd1; phase_r <= PH_T;
            end
          end
          default: phase_r <= PH_T;
        endcase
      end
      if (state_r == ST_OUT && out_tready) begin
        if (j_r == LAST_NODE) begin
          j_r <= '0;
          i_r <= i_r + 2'd1;
        end else j_r <= j_r + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser != KIND_HEADER) begin
      for (int c = 0; c < 3; c++) grad_r[{slot, 2'b00} - {2'b00, slot} + 4'(c)]
        <= in_tdata[(7+c)*DW +: DW];
    end
    if (state_r == ST_MUL) prod_r <= PW'(opa) * PW'(opb);
    if (state_r == ST_IDLE || state_r == ST_OUT) begin
      acc_r <= '0; dacc_r <= '0; clip_r <= 1'b0;
    end
    if (state_r == ST_ACC) begin
      case (phase_r)
        PH_T: begin
          if (l_r == 2'd2) begin
            t_r   <= ssat[DW-1:0];
            clip_r <= clip_r | pclip | ssat[AW];
            acc_r <= dacc_r;
          end else begin
            clip_r <= clip_r | pclip;
            acc_r <= sum;
          end
        end
        PH_D: begin
          if (k_r == 2'd2) begin
            dacc_r <= ssat[AW-1:0];
            clip_r <= clip_r | pclip | ssat[AW];
          end else begin
            clip_r <= clip_r | pclip;
            dacc_r <= sum;
            acc_r  <= '0;
          end
        end
        default: begin
          odata_r <= {3'b0, clip_r | pclip, prs[DW-1:0], j_r, i_r};
          olast_r <= (i_r == LAST_NODE) && (j_r == LAST_NODE);
        end
      endcase
    end
  end

  // checks
  `TES_ASSERT_IMP(a_busy_not_ready, state_r != ST_IDLE, !in_tready)
  `TES_ASSERT_IMP(a_last_pos, out_tvalid && out_tlast, i_r == LAST_NODE && j_r == LAST_NODE)
  `TES_ASSERT_NXT(a_done_idle, out_tvalid && out_tready && out_tlast, in_tready)
endmodule

/* sim/tb_tet_element_stiffness.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tet_element_stiffness
// Self-checking bench for the tetrahedral element stiffness block. Headers and
// node gradients are streamed in with random gaps. An in-bench fixed-point
// model predicts the sixteen entries of each element. Every entry is checked
// field by field while the output side stalls at random, including one long
// hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_tet_element_stiffness;
  import tes_pkg::*;

  localparam int DW     = 32;
  localparam int NODES  = 4;
  localparam int IN_W   = 10*DW+8;
  localparam int OUT_W  = DW+8;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  // one predicted entry
  typedef struct {
    logic [1:0]    row;
    logic [1:0]    col;
    logic [DW-1:0] value;
    logic          clip;
    logic          last;
  } entry_t;

  // element matrix predictor and store of pending entries
  class stiffness_scoreboard;
    longint tensor[6];
    longint vol;
    longint grad[NODES][3];
    entry_t pending[$];
    int     errors;
    int     entries_seen;

    function new();
      for (int k = 0; k < 6; k++) tensor[k] = 0;
      for (int n = 0; n < NODES; n++)
        for (int k = 0; k < 3; k++) grad[n][k] = 0;
      vol = 0;
      errors = 0;
      entries_seen = 0;
    endfunction

    function longint clamp(longint x, inout bit clip);
      if (x > QMAX) begin
        clip = 1;
        return QMAX;
      end
      if (x < QMIN) begin
        clip = 1;
        return QMIN;
      end
      return x;
    endfunction

    // q16.16 product, floor rounding, saturated
    function longint qmul(longint a, longint b, inout bit clip);
      longint p;
      p = (a * b) >>> 16;
      return clamp(p, clip);
    endfunction

    function int tidx(int k, int l);
      if (k == l) return (k == 0) ? 0 : (k == 1) ? 3 : 5;
      if (k + l == 1) return 1;
      if (k + l == 2) return 2;
      return 4;
    endfunction

    // note an accepted input item
    function void note_item(logic kind, logic [IN_W-1:0] d);
      int slot;
      longint t, acc;
      bit clip;
      entry_t e;
      if (kind == KIND_HEADER) begin
        for (int k = 0; k < 6; k++) tensor[k] = longint'($signed(d[k*DW +: DW]));
        vol = longint'($signed(d[6*DW +: DW]));
        return;
      end
      slot = int'(d[10*DW +: 2]);
      for (int k = 0; k < 3; k++) grad[slot][k] = longint'($signed(d[(7+k)*DW +: DW]));
      if (slot != NODES-1) return;
      for (int i = 0; i < NODES; i++)
        for (int j = 0; j < NODES; j++) begin
          clip = 0;
          acc = 0;
          for (int k = 0; k < 3; k++) begin
            t = 0;
            for (int l = 0; l < 3; l++) t += qmul(tensor[tidx(k, l)], grad[j][l], clip);
            t = clamp(t, clip);
            acc += qmul(grad[i][k], t, clip);
          end
          acc = clamp(acc, clip);
          e.row   = 2'(i);
          e.col   = 2'(j);
          e.value = DW'(qmul(vol, acc, clip));
          e.clip  = clip;
          e.last  = (i == NODES-1) && (j == NODES-1);
          pending.push_back(e);
        end
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_entry(logic [OUT_W-1:0] d, logic last);
      entry_t e;
      entries_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected entry tdata=%h tlast=%b", $time, d, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.row) begin
        $display("%0t: row expected %0d actual %0d", $time, e.row, d[1:0]);
        errors++;
      end
      if (d[3:2] !== e.col) begin
        $display("%0t: col expected %0d actual %0d", $time, e.col, d[3:2]);
        errors++;
      end
      if (d[4 +: DW] !== e.value) begin
        $display("%0t: entry (%0d,%0d) value expected %h actual %h", $time,
                 e.row, e.col, e.value, d[4 +: DW]);
        errors++;
      end
      if (d[4+DW] !== e.clip) begin
        $display("%0t: entry (%0d,%0d) saturated expected %b actual %b", $time,
                 e.row, e.col, e.clip, d[4+DW]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: entry (%0d,%0d) tlast expected %b actual %b", $time,
                 e.row, e.col, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  stiffness_scoreboard sb;
  bit  calm;
  bit  hold_done;
  int  items_sent;
  int  elements_sent;

  tet_element_stiffness #(
    .NODES_PER_ELEMENT(NODES),
    .DATA_WIDTH(DW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // q16.16 operand mix: mostly modest values, some extremes and raw bits
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      7:       return 32'h7fffffff;
      8:       return 32'h80000000;
      9:       return 32'h0;
      6:       return $urandom;
      default: return $urandom_range(0, 8 << 16) - (4 << 16);
    endcase
  endfunction

  // send one item and note it once accepted
  task automatic send_item(logic kind, logic [IN_W-1:0] d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, d);
    items_sent++;
  endtask

  task automatic send_header(logic [DW-1:0] sxx, logic [DW-1:0] sxy, logic [DW-1:0] sxz,
                             logic [DW-1:0] syy, logic [DW-1:0] syz, logic [DW-1:0] szz,
                             logic [DW-1:0] v);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: DW] = sxx; d[DW +: DW] = sxy; d[2*DW +: DW] = sxz;
    d[3*DW +: DW] = syy; d[4*DW +: DW] = syz; d[5*DW +: DW] = szz;
    d[6*DW +: DW] = v;
    // unused gradient and slot fields carry noise on some headers
    if ($urandom_range(0, 1)) begin
      d[7*DW +: DW] = $urandom; d[8*DW +: DW] = $urandom; d[9*DW +: DW] = $urandom;
      d[10*DW +: 8] = 8'($urandom);
    end
    send_item(KIND_HEADER, d);
  endtask

  task automatic send_grad(int slot, logic [DW-1:0] gx, logic [DW-1:0] gy,
                           logic [DW-1:0] gz);
    logic [IN_W-1:0] d;
    d = '0;
    if ($urandom_range(0, 1))
      for (int k = 0; k < 7; k++) d[k*DW +: DW] = $urandom;
    d[7*DW +: DW] = gx; d[8*DW +: DW] = gy; d[9*DW +: DW] = gz;
    d[10*DW +: 2] = 2'(slot);
    d[10*DW+2 +: 6] = 6'($urandom);
    send_item(~KIND_HEADER, d);
    if (slot == NODES-1) elements_sent++;
  endtask

  task automatic random_header();
    send_header(pick_value(), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), pick_value());
  endtask

  task automatic random_grad(int slot);
    send_grad(slot, pick_value(), pick_value(), pick_value());
  endtask

  // well-formed element: header, early slots in random order, last slot
  task automatic random_element();
    int order[3];
    int a, b, tmp;
    order = '{0, 1, 2};
    repeat (3) begin
      a = $urandom_range(0, 2); b = $urandom_range(0, 2);
      tmp = order[a]; order[a] = order[b]; order[b] = tmp;
    end
    random_header();
    for (int k = 0; k < 3; k++) random_grad(order[k]);
    random_grad(NODES-1);
  endtask

  // output side: random stalls, one long hold once entries are flowing
  initial begin
    int w;
    out_tready = 1'b0;
    hold_done = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!hold_done && sb.entries_seen >= 40) begin
        w = 700;
        hold_done = 1;
      end else begin
        w = calm ? 0 : $urandom_range(0, 4);
      end
      repeat (w) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_entry(out_tdata, out_tlast);
  end

  // stimulus
  initial begin
    int wait_cycles;
    sb = new();
    calm = 0;
    items_sent = 0;
    elements_sent = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // element straight after reset: tensor and volume still zero
    send_grad(0, 32'h00010000, 32'h00020000, 32'h00030000);
    send_grad(1, 32'hffff0000, 32'h0, 32'h00008000);
    send_grad(2, 32'h7fffffff, 32'h80000000, 32'h0);
    send_grad(3, 32'h00010000, 32'hffff8000, 32'h00010000);
    // identity tensor, unit volume, slots out of order, slot 1 written twice
    send_header(32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h00010000,
                32'h00010000);
    send_grad(2, 32'h00010000, 32'h0, 32'h0);
    send_grad(1, 32'h0, 32'h00010000, 32'h0);
    send_grad(0, 32'hffff0001, 32'h00000003, 32'hfffffffd);
    send_grad(1, 32'h0, 32'hffff0000, 32'h00020000);
    send_grad(3, 32'h00000001, 32'hffffffff, 32'h00001234);
    // extreme tensor and volume, saturating every stage
    send_header(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff);
    send_grad(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_grad(1, 32'h80000000, 32'h80000000, 32'h80000000);
    send_grad(2, 32'h7fffffff, 32'h80000000, 32'h00000001);
    send_grad(3, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    // negative volume, then zero volume, last slot repeated alone
    send_header(32'h00020000, 32'hffff8000, 32'h00004000, 32'h00030000, 32'h0,
                32'h00010000, 32'h80000000);
    send_grad(3, 32'h00008000, 32'hffff0000, 32'h00010000);
    send_header(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h0);
    send_grad(3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);

    // random part: mostly well-formed elements, a calm stretch, some noise
    while (items_sent < 450) begin
      calm = (elements_sent % 20) >= 15;
      case ($urandom_range(0, 9))
        0:       random_header();
        1:       random_grad($urandom_range(0, 3));
        default: random_element();
      endcase
    end
    calm = 0;
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    $display("covered %0d items, %0d elements, %0d entries checked",
             items_sent, elements_sent, sb.entries_seen);
    $display("headers, out-of-order and rewritten slots, saturation and output back-pressure");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_tet_element_stiffness: done, clean");
    end else begin
      $display("%0d mismatches, %0d entries never seen", sb.errors, sb.pending.size());
      $display("tb_tet_element_stiffness: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("tb_tet_element_stiffness: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/tes_pkg.sv
design/tet_element_stiffness.sv
sim/tb_tet_element_stiffness.sv
